[rtl/i64dr_pkg.sv]
// Package for the 64-bit divider: field widths, defaults and the per-stage control bundle.
`default_nettype none

package i64dr_pkg;

    localparam int FIELD_WIDTH        = 64;
    localparam int DATA_WIDTH_DEFAULT = 64;

    typedef logic [FIELD_WIDTH-1:0] t_field;

    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
        logic div_zero;
    } t_ctrl;

endpackage

`default_nettype wire

[rtl/i64dr_req_if.sv]
// Request channel of the divider: mode, dividend and divisor with valid/ready.
`default_nettype none

interface i64dr_req_if;
    logic                valid;
    logic                ready;
    logic                func;
    i64dr_pkg::t_field   dividend;
    i64dr_pkg::t_field   divisor;

    modport source (output valid, output func, output dividend, output divisor, input ready);
    modport sink   (input valid, input func, input dividend, input divisor, output ready);
endinterface

`default_nettype wire

[rtl/i64dr_rsp_if.sv]
// Response channel of the divider: quotient and remainder with valid/ready.
`default_nettype none

interface i64dr_rsp_if;
    logic                valid;
    logic                ready;
    i64dr_pkg::t_field   quotient;
    i64dr_pkg::t_field   remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

`default_nettype wire

[rtl/i64dr_step.sv]
// One registered restoring division step: shift in a dividend bit, subtract when it fits.
`default_nettype none

module i64dr_step #(
    parameter int DATA_WIDTH = i64dr_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire i64dr_pkg::t_ctrl      i_ctrl,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_acc,
    input  wire logic [DATA_WIDTH-1:0] i_den,
    output i64dr_pkg::t_ctrl           o_ctrl,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_acc,
    output logic [DATA_WIDTH-1:0]      o_den
);

    i64dr_pkg::t_ctrl        r_ctrl;
    logic [DATA_WIDTH-1:0]   r_rem;
    logic [DATA_WIDTH-1:0]   r_acc;
    logic [DATA_WIDTH-1:0]   r_den;

    logic [DATA_WIDTH:0]     shifted;
    logic [DATA_WIDTH:0]     diff;
    logic                    fits;
    logic [DATA_WIDTH-1:0]   n_rem;
    logic [DATA_WIDTH-1:0]   n_acc;

    always_comb begin
        shifted = {i_rem, i_acc[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, i_den};
        fits    = !diff[DATA_WIDTH];
        n_rem   = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        n_acc   = {i_acc[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_den <= i_den;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;
    assign o_den  = r_den;

endmodule

`default_nettype wire

[rtl/int64_divide_remainder.sv]
// Top level of the pipelined signed/unsigned restoring divider.
//
//  channel  dir  payload                         transfer
//  i_req    in   func, dividend, divisor         valid && ready
//  o_rsp    out  quotient, remainder             valid && ready
//
//  The pipeline has an operand stage, one stage per quotient bit, and a
//  sign-fix output register. One transfer is taken every cycle while i_req.ready is high.
//  The whole pipeline advances together; it holds only while the output
//  register is full and o_rsp.ready is low, and then i_req.ready is low.
//  Reset clears the valid bits of every stage.
`default_nettype none

module int64_divide_remainder #(
    parameter int DATA_WIDTH = i64dr_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i64dr_req_if.sink   i_req,
    i64dr_rsp_if.source o_rsp
);

    logic                    en;

    logic [DATA_WIDTH-1:0]   a;
    logic [DATA_WIDTH-1:0]   b;
    logic                    sa;
    logic                    sb;
    logic [DATA_WIDTH-1:0]   n_ua;
    logic [DATA_WIDTH-1:0]   n_ub;
    i64dr_pkg::t_ctrl        n_s0_ctrl;

    i64dr_pkg::t_ctrl        r_s0_ctrl;
    logic [DATA_WIDTH-1:0]   r_s0_acc;
    logic [DATA_WIDTH-1:0]   r_s0_den;

    i64dr_pkg::t_ctrl        ctrl [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]   rem  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]   acc  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]   den  [0:DATA_WIDTH];

    logic [DATA_WIDTH-1:0]   n_q;
    logic [DATA_WIDTH-1:0]   n_r;
    logic                    r_out_valid;
    logic [DATA_WIDTH-1:0]   r_out_q;
    logic [DATA_WIDTH-1:0]   r_out_r;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    // operand stage: take magnitudes in signed mode
    always_comb begin
        a                  = i_req.dividend[DATA_WIDTH-1:0];
        b                  = i_req.divisor[DATA_WIDTH-1:0];
        sa                 = i_req.func && a[DATA_WIDTH-1];
        sb                 = i_req.func && b[DATA_WIDTH-1];
        n_ua               = sa ? ({DATA_WIDTH{1'b0}} - a) : a;
        n_ub               = sb ? ({DATA_WIDTH{1'b0}} - b) : b;
        n_s0_ctrl.valid    = i_req.valid;
        n_s0_ctrl.neg_q    = sa ^ sb;
        n_s0_ctrl.neg_r    = sa;
        n_s0_ctrl.div_zero = (b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctrl <= '0;
        end else if (en) begin
            r_s0_ctrl <= n_s0_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_acc <= n_ua;
            r_s0_den <= n_ub;
        end
    end

    assign ctrl[0] = r_s0_ctrl;
    assign rem[0]  = '0;
    assign acc[0]  = r_s0_acc;
    assign den[0]  = r_s0_den;

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        i64dr_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctrl  (ctrl[k]),
            .i_rem   (rem[k]),
            .i_acc   (acc[k]),
            .i_den   (den[k]),
            .o_ctrl  (ctrl[k+1]),
            .o_rem   (rem[k+1]),
            .o_acc   (acc[k+1]),
            .o_den   (den[k+1])
        );
    end

    // output stage: restore signs, drop results of a zero divisor
    always_comb begin
        if (ctrl[DATA_WIDTH].div_zero) begin
            n_q = '0;
            n_r = '0;
        end else begin
            n_q = ctrl[DATA_WIDTH].neg_q ? ({DATA_WIDTH{1'b0}} - acc[DATA_WIDTH])
                                         : acc[DATA_WIDTH];
            n_r = ctrl[DATA_WIDTH].neg_r ? ({DATA_WIDTH{1'b0}} - rem[DATA_WIDTH])
                                         : rem[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= ctrl[DATA_WIDTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_q <= n_q;
            r_out_r <= n_r;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.quotient  = i64dr_pkg::t_field'(r_out_q);
    assign o_rsp.remainder = i64dr_pkg::t_field'(r_out_r);

endmodule

`default_nettype wire
